[rtl/core/tnss_pkg.sv]
// Package for the top-N smallest selector: word types, config constants,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package tnss_pkg;

    localparam int KEEP_COUNT_W = 5;
    localparam logic [KEEP_COUNT_W-1:0] KEEP_COUNT_RESET = 5'd16;

    // Register index, taken from paddr[2]
    localparam logic REG_KEEP_COUNT = 1'b0;

    // Request codes
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_END    = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [63:0] sort_key;
        logic [31:0] record_tag;
    } req_word_t;

    typedef struct packed {
        logic [63:0] out_key;
        logic [31:0] out_tag;
        logic        out_valid;
        logic        out_last;
    } rsp_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_EMIT
    } tnss_state_t;

    typedef struct packed {
        logic load;    // latch the incoming word
        logic insert;  // insert latched record into the sorted store
        logic emit;    // emit the head entry and shift the store
    } tnss_cmd_t;

    typedef struct packed {
        logic emit_last;  // the entry emitted this cycle ends the group
    } tnss_status_t;

endpackage

[rtl/core/top_n_smallest_selector_unit.sv]
// Top level of the top-N smallest selector: APB config register, controller
// and datapath. Depends on tnss_pkg, tnss_ctrl, tnss_datapath.

// Keeps the keep_count smallest keys of a record stream (ties kept in arrival
// order, an equal key to the largest held is dropped) and on an end-of-group
// word emits them in ascending order, one result per cycle, the last flagged;
// an empty group gives one invalid result flagged last. A word is taken when
// start is high and busy is low. A record word is latched, then inserted in a
// step in which every store cell compares against the key and the list shifts
// open at the insertion point. An end-of-group word is latched, then takes one
// emit step per entry held, or one if the group is empty; each result is on
// rsp in the cycle after its emit step, with rsp_strobe high for one cycle,
// and cannot be stalled. keep_count is written over APB at byte address 0.
module top_n_smallest_selector_unit
    import tnss_pkg::*;
#(
    parameter int MAX_KEEP = 16,
    parameter int KEY_BITS = 64,
    parameter int TAG_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_word_t   req,
    output rsp_word_t   rsp,
    output logic        rsp_strobe,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [KEEP_COUNT_W-1:0] keep_count_reg;
    logic                    reg_idx;
    tnss_cmd_t               cmd;
    tnss_status_t            status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KEEP_COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready && (reg_idx == REG_KEEP_COUNT))
        begin
            keep_count_reg <= pwdata[KEEP_COUNT_W-1:0];
        end
    end

    assign prdata = (reg_idx == REG_KEEP_COUNT) ? 32'(keep_count_reg) : '0;

    tnss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    tnss_datapath #(
        .MAX_KEEP (MAX_KEEP),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .keep_count (keep_count_reg),
        .cmd        (cmd),
        .status     (status),
        .rsp        (rsp),
        .rsp_strobe (rsp_strobe)
    );

    // every accepted word makes the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // results only come out of an emit step
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_strobe |-> $past(busy))
        else $error("result strobe without emit step");

    // more results pending: still emitting
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_strobe && !rsp.out_last |-> busy)
        else $error("group ended without last flag");

    // an empty-group result is always the last one
    a_invalid_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_strobe && !rsp.out_valid |-> rsp.out_last)
        else $error("invalid result not flagged last");

endmodule

[rtl/core/tnss_ctrl.sv]
// Controller of the top-N smallest selector: sequences load, insert and emit.
// Depends on tnss_pkg.
module tnss_ctrl
    import tnss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         req_type,
    input  tnss_status_t status,
    output tnss_cmd_t    cmd,
    output logic         busy
);

    tnss_state_t state_reg;
    tnss_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (req_type == REQ_END) ? ST_EMIT : ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/tnss_datapath.sv]
// Datapath of the top-N smallest selector: sorted insertion store, fill count
// and result register. Depends on tnss_pkg.
module tnss_datapath
    import tnss_pkg::*;
#(
    parameter int MAX_KEEP = 16,
    parameter int KEY_BITS = 64,
    parameter int TAG_BITS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  req_word_t               req,
    input  logic [KEEP_COUNT_W-1:0] keep_count,
    input  tnss_cmd_t               cmd,
    output tnss_status_t            status,
    output rsp_word_t               rsp,
    output logic                    rsp_strobe
);

    localparam int CNT_W = $clog2(MAX_KEEP + 1);
    localparam int NW    = (CNT_W > KEEP_COUNT_W) ? CNT_W : KEEP_COUNT_W;
    localparam int TAG_W = (TAG_BITS < 32) ? TAG_BITS : 32;

    // Store cells, ascending by key, equal keys in arrival order
    logic [KEY_BITS-1:0] key_reg  [MAX_KEEP];
    logic [KEY_BITS-1:0] key_next [MAX_KEEP];
    logic [TAG_W-1:0]    tag_reg  [MAX_KEEP];
    logic [TAG_W-1:0]    tag_next [MAX_KEEP];

    logic [KEY_BITS-1:0] in_key_reg;
    logic [TAG_W-1:0]    in_tag_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    rsp_word_t           rsp_reg;
    rsp_word_t           rsp_next;
    logic                strobe_reg;

    logic [NW-1:0]       kc_ext;
    logic [NW-1:0]       n_eff;
    logic [CNT_W-1:0]    fill_eff;
    logic                full;
    logic                do_ins;
    logic [MAX_KEEP-1:0] valid;
    logic [MAX_KEEP-1:0] le;

    always_comb
    begin
        kc_ext = NW'(keep_count);
        priority if (kc_ext == '0)
        begin
            n_eff = NW'(1);
        end
        else if (kc_ext > NW'(MAX_KEEP))
        begin
            n_eff = NW'(MAX_KEEP);
        end
        else
        begin
            n_eff = kc_ext;
        end
        // a lowered keep_count drops the largest entries at once
        fill_eff = (NW'(fill_reg) > n_eff) ? CNT_W'(n_eff) : fill_reg;
        full     = (NW'(fill_eff) == n_eff);
    end

    // Per-cell compare: thermometer of entries that stay ahead of the new key
    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            valid[i] = (CNT_W'(i) < fill_eff);
            le[i]    = valid[i] && (key_reg[i] <= in_key_reg);
        end
        do_ins = !full || |(valid & ~le);
    end

    always_comb
    begin
        key_next  = key_reg;
        tag_next  = tag_reg;
        fill_next = fill_reg;
        rsp_next  = rsp_reg;
        if (cmd.insert)
        begin
            fill_next = fill_eff;
            if (do_ins)
            begin
                // head cell has nothing ahead of it: it takes the new word or stays
                if (!le[0])
                begin
                    key_next[0] = in_key_reg;
                    tag_next[0] = in_tag_reg;
                end
                for (int i = 1; i < MAX_KEEP; i++)
                begin
                    if (!le[i])
                    begin
                        if (le[i-1])
                        begin
                            key_next[i] = in_key_reg;
                            tag_next[i] = in_tag_reg;
                        end
                        else
                        begin
                            key_next[i] = key_reg[i-1];
                            tag_next[i] = tag_reg[i-1];
                        end
                    end
                end
                fill_next = full ? fill_eff : fill_eff + CNT_W'(1);
            end
        end
        else if (cmd.emit)
        begin
            if (fill_eff == '0)
            begin
                rsp_next.out_key   = '0;
                rsp_next.out_tag   = '0;
                rsp_next.out_valid = 1'b0;
                rsp_next.out_last  = 1'b1;
                fill_next          = '0;
            end
            else
            begin
                rsp_next.out_key   = 64'(key_reg[0]);
                rsp_next.out_tag   = 32'(tag_reg[0]);
                rsp_next.out_valid = 1'b1;
                rsp_next.out_last  = (fill_eff == CNT_W'(1));
                fill_next          = fill_eff - CNT_W'(1);
                for (int i = 0; i < MAX_KEEP - 1; i++)
                begin
                    key_next[i] = key_reg[i+1];
                    tag_next[i] = tag_reg[i+1];
                end
            end
        end
    end

    assign status.emit_last = (fill_eff <= CNT_W'(1));

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
        rsp_reg <= rsp_next;
        if (cmd.load)
        begin
            in_key_reg <= req.sort_key[KEY_BITS-1:0];
            in_tag_reg <= req.record_tag[TAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            strobe_reg <= cmd.emit;
        end
    end

    assign rsp        = rsp_reg;
    assign rsp_strobe = strobe_reg;

endmodule
